@@ rtl/qom_pkg.sv @@
// Package for the quantile outlier marker: shared types, constants and decade table.
// No dependencies.
package qom_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned ONE_Q16 = 65536;

  typedef enum logic [2:0] {
    CFG_TOP_FRAC = 3'd0,
    CFG_TOP_ERR  = 3'd1,
    CFG_TOP_MAG  = 3'd2,
    CFG_BOT_FRAC = 3'd3,
    CFG_BOT_ERR  = 3'd4,
    CFG_BOT_MAG  = 3'd5,
    CFG_MODE     = 3'd6
  } cfg_idx_t;

  // Shift command sent down the sorting chain.
  typedef struct packed {
    logic               ins;    // insert value this cycle
    logic signed [31:0] value;
  } cell_cmd_t;

  // Decade of a nonnegative Q.16 value, zero for zero.
  function automatic logic [29:0] decade_of(input logic signed [63:0] q);
    logic [29:0] d;
    d = 30'd0;
    if (q > 64'sd0) begin
      d = 30'd7;
      if (q >= 64'sd66)        d = 30'd66;
      if (q >= 64'sd656)       d = 30'd655;
      if (q >= 64'sd6554)      d = 30'd6554;
      if (q >= 64'sd65536)     d = 30'd65536;
      if (q >= 64'sd655360)    d = 30'd655360;
      if (q >= 64'sd6553600)   d = 30'd6553600;
      if (q >= 64'sd65536000)  d = 30'd65536000;
      if (q >= 64'sd655360000) d = 30'd655360000;
    end
    return d;
  endfunction

  function automatic logic [16:0] sat_one(input logic [16:0] x);
    return (x > 17'd65536) ? 17'd65536 : x;
  endfunction

endpackage

@@ rtl/qom_sort_cell.sv @@
// One cell of the insertion sort chain: holds one sorted value.
// Depends on qom_pkg.
module qom_sort_cell (
  input  logic                      clk,
  input  logic                      clear,
  input  qom_pkg::cell_cmd_t        cmd,
  input  logic                      left_valid,
  input  logic signed [31:0]        left_value,
  output logic                      cell_valid,
  output logic signed [31:0]        cell_value
);
  import qom_pkg::*;

  logic               valid_r, valid_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic               take_left;

  // Cell holds a value greater than the new one: shift right. The first empty cell
  // after the filled ones takes the new value or its neighbor's; later empty cells hold.
  always_comb begin
    take_left = valid_r && (value_r > cmd.value);
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.ins && (take_left || (!valid_r && left_valid))) begin
      valid_nxt = 1'b1;
      value_nxt = (left_valid && left_value > cmd.value) ? left_value : cmd.value;
    end
    if (clear) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    valid_r <= valid_nxt;
    value_r <= value_nxt;
  end

  assign cell_valid = valid_r;
  assign cell_value = value_r;
endmodule

@@ rtl/qom_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module qom_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/quantile_outlier_marker.sv @@
// Quantile outlier marker, top level: load, sort chain, threshold sequencer, emit.
// Depends on qom_pkg, qom_sort_cell, qom_ram.
//
// While loading, samples are taken one per cycle into a column RAM, and present values
// enter a chain of MAX_LEN sort cells that keeps them in ascending order. On the closing
// sample, a short sequencer (two quantile selections, two interpolation multiplies, two
// threshold products and a compare) forms both type-7 quantiles and thresholds; the column
// is then read back from the RAM and emitted, each result by a RAM read and then an output
// load. The chain is cleared after the last result is taken; the next column is accepted
// once the last result of the previous one has been taken.
module quantile_outlier_marker #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_sample_missing,
  input  logic               in_sample_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_out_value,
  output logic               out_out_missing,
  output logic               out_out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import qom_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_SEL  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_THR  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // configuration
  logic [16:0] top_frac_r, top_err_r, bot_frac_r, bot_err_r;
  logic [23:0] top_mag_r, bot_mag_r;
  logic        mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_frac_r <= 17'd65536;
      top_err_r  <= '0;
      top_mag_r  <= '0;
      bot_frac_r <= '0;
      bot_err_r  <= '0;
      bot_mag_r  <= '0;
      mode_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOP_FRAC: top_frac_r <= cfg_data[16:0];
        CFG_TOP_ERR:  top_err_r  <= cfg_data[16:0];
        CFG_TOP_MAG:  top_mag_r  <= cfg_data;
        CFG_BOT_FRAC: bot_frac_r <= cfg_data[16:0];
        CFG_BOT_ERR:  bot_err_r  <= cfg_data[16:0];
        CFG_BOT_MAG:  bot_mag_r  <= cfg_data;
        CFG_MODE:     mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_t             state_r;
  logic [CW-1:0]      cnt_r, pres_r;
  logic signed [31:0] min_r, max_r;
  logic [2:0]         step_r;
  logic [CW-1:0]      rd_r;
  logic               rd_pend_r;

  logic in_acc;
  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;

  logic pres_in, closing;
  assign pres_in = in_acc && !in_sample_missing && (pres_r < CW'(MAX_LEN));
  assign closing = in_acc && (in_sample_last || cnt_r >= CW'(MAX_LEN - 1));

  // sort chain
  cell_cmd_t          cmd;
  logic               clr;
  logic [MAX_LEN-1:0] cv;
  logic signed [31:0] cval [MAX_LEN];

  assign cmd.ins   = pres_in;
  assign cmd.value = in_sample_value;
  assign clr       = !rst_n || (state_r == ST_EMIT && rd_r == cnt_r && !rd_pend_r
                     && !out_valid);

  // the first cell sees a filled neighbor holding the most negative value
  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    qom_sort_cell u_cell (
      .clk       (clk),
      .clear     (clr),
      .cmd       (cmd),
      .left_valid(g == 0 ? 1'b1 : cv[(g == 0) ? 0 : g-1]),
      .left_value(g == 0 ? 32'sh80000000 : cval[(g == 0) ? 0 : g-1]),
      .cell_valid(cv[g]),
      .cell_value(cval[g])
    );
  end

  // column RAM; hold the read address while a word waits for the output register
  logic [AW-1:0] waddr, raddr;
  logic [32:0]   rdata;
  assign waddr = (cnt_r >= CW'(MAX_LEN)) ? AW'(MAX_LEN - 1) : cnt_r[AW-1:0];
  assign raddr = rd_pend_r ? AW'(rd_r - CW'(1)) : rd_r[AW-1:0];

  qom_ram #(.WIDTH(33), .DEPTH(MAX_LEN)) u_col (
    .clk  (clk),
    .we   (in_acc),
    .waddr(waddr),
    .wdata({in_sample_missing, in_sample_value}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // quantile selection: one side per step (step 0 top, 1 bottom)
  logic [16:0]        p_sel;
  logic [CW+16:0]     idx;
  logic [CW-1:0]      lo;
  logic [15:0]        fr;
  logic signed [31:0] vlo, vhi;
  logic               use_hi;
  assign p_sel  = sat_one(step_r[0] ? bot_frac_r : top_frac_r);
  assign idx    = (CW+17)'(pres_r - CW'(1)) * (CW+17)'(p_sel);
  assign lo     = CW'(idx >> 16);
  assign fr     = idx[15:0];
  assign vlo    = cval[lo[AW-1:0]];
  assign vhi    = cval[(lo + CW'(1) >= CW'(MAX_LEN)) ? AW'(MAX_LEN-1) : AW'(lo + CW'(1))];
  assign use_hi = (fr != 16'd0) && (lo + CW'(1) < pres_r);

  logic signed [32:0] d_r [2];
  logic signed [31:0] b_r [2];
  logic        [15:0] f_r [2];
  logic signed [63:0] q_r [2];
  logic signed [63:0] ta_r [2], tb_r [2];
  logic               mhi_r, mlo_r;

  logic signed [63:0] prod;
  assign prod = 64'(d_r[step_r[0]]) * $signed({1'b0, f_r[step_r[0]]});

  logic signed [63:0] qa;
  logic signed [18:0] ffac;
  logic        [29:0] dec;
  logic        [23:0] mag;
  assign qa   = q_r[step_r[0]];
  assign ffac = step_r[0] ? 19'sd65536 - $signed({2'b0, sat_one(bot_err_r)})
                          : 19'sd65536 + $signed({2'b0, sat_one(top_err_r)});
  assign dec  = decade_of(qa);
  assign mag  = step_r[0] ? bot_mag_r : top_mag_r;

  logic signed [63:0] th_t, th_b;
  assign th_t = (ta_r[0] >>> 16) + (tb_r[0] >>> 16);
  assign th_b = (ta_r[1] >>> 16) - (tb_r[1] >>> 16);

  // output register
  logic ld_out;
  logic last_rd;
  logic mark;
  assign last_rd = (rd_r == cnt_r);
  always_comb begin
    mark = 1'b0;
    if (!rdata[32] && pres_r != '0) begin
      if (mode_r)
        mark = (mhi_r && rdata[31:0] == max_r) || (mlo_r && rdata[31:0] == min_r);
      else
        mark = (64'($signed(rdata[31:0])) > q_r[0]) || (64'($signed(rdata[31:0])) < q_r[1]);
    end
  end
  assign ld_out = rd_pend_r && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      pres_r    <= '0;
      min_r     <= 32'sh7fffffff;
      max_r     <= 32'sh80000000;
      step_r    <= '0;
      rd_r      <= '0;
      rd_pend_r <= 1'b0;
      out_valid <= 1'b0;
      mhi_r     <= 1'b0;
      mlo_r     <= 1'b0;
    end else begin
      if (out_valid && out_ready && !ld_out) out_valid <= 1'b0;
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            cnt_r <= (cnt_r >= CW'(MAX_LEN)) ? CW'(MAX_LEN) : cnt_r + CW'(1);
            if (pres_in) begin
              pres_r <= pres_r + CW'(1);
              if (in_sample_value < min_r) min_r <= in_sample_value;
              if (in_sample_value > max_r) max_r <= in_sample_value;
            end
            if (closing) begin
              state_r <= ST_SEL;
              step_r  <= '0;
            end
          end
        end
        ST_SEL: begin
          d_r[step_r[0]] <= use_hi ? 33'(vhi) - 33'(vlo) : 33'sd0;
          b_r[step_r[0]] <= vlo;
          f_r[step_r[0]] <= fr;
          if (step_r[0]) begin
            state_r <= ST_MUL;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_MUL: begin
          q_r[step_r[0]] <= 64'(b_r[step_r[0]]) + (prod >>> 16);
          if (step_r[0]) begin
            state_r <= ST_THR;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_THR: begin
          // steps 0,1 form products; step 2 compares
          if (step_r < 3'd2) begin
            ta_r[step_r[0]] <= 64'($signed(qa[32:0])) * 64'(ffac);
            tb_r[step_r[0]] <= $signed({34'd0, dec}) * $signed({40'd0, mag});
          end else begin
            mhi_r   <= mode_r && pres_r != '0 && q_r[0] >= 0 && 64'(max_r) > th_t;
            mlo_r   <= mode_r && pres_r != '0 && q_r[1] >= 0 && 64'(min_r) < th_b;
            state_r <= ST_EMIT;
            rd_r    <= '0;
          end
          step_r <= step_r + 3'd1;
        end
        ST_EMIT: begin
          // advance the read pointer whenever the RAM word will be consumed
          if (!rd_pend_r && !last_rd) begin
            rd_pend_r <= 1'b1;
            rd_r      <= rd_r + CW'(1);
          end else if (ld_out) begin
            out_valid       <= 1'b1;
            out_out_value   <= rdata[31:0];
            out_out_missing <= rdata[32] || mark;
            out_out_last    <= last_rd;
            rd_pend_r       <= 1'b0;
          end
          if (clr) begin
            state_r <= ST_LOAD;
            cnt_r   <= '0;
            pres_r  <= '0;
            min_r   <= 32'sh7fffffff;
            max_r   <= 32'sh80000000;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // assertions
  a_no_in_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> !in_ready) else $error("input taken during emit");
  a_pres_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    pres_r <= cnt_r) else $error("present count above sample count");
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cv[0] && cv[1]) |-> cval[0] <= cval[1]) else $error("chain out of order");
endmodule
